// File: rtl/rc4sc_pkg.sv
// Package for the RC4 stream cipher core: sizes, codes, sequencer states
// and the structs passed between the top level and the engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rc4sc_pkg;

   localparam int TABLE_SIZE    = 256;
   localparam int ADDR_W        = $clog2(TABLE_SIZE);
   localparam int BYTE_W        = 8;
   localparam int MAX_KEY_BYTES = 16;
   localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
   localparam int LEN_W         = 5;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 64;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_SIZE - 1);
   localparam logic [LEN_W-1:0]  KEY_LEN_MAX = LEN_W'(MAX_KEY_BYTES);
   localparam logic [LEN_W-1:0]  KEY_LEN_MIN = LEN_W'(1);

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LEN  = CSR_IDX_W'(2);

   localparam logic REQ_REKEY = 1'b0;
   localparam logic REQ_DATA  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_KS_RD_I,
      ST_KS_RD_J,
      ST_KS_WR_J,
      ST_KS_WR_I,
      ST_GEN_RD_I,
      ST_GEN_RD_J,
      ST_GEN_WR_J,
      ST_GEN_WR_I,
      ST_GEN_RD_K,
      ST_RESULT
   } rc4sc_state_type;

   typedef struct packed {
      logic valid;
      logic is_data;
   } rc4sc_start_type;

   typedef struct packed {
      logic [MAX_KEY_BYTES-1:0][BYTE_W-1:0] bytes;
      logic [LEN_W-1:0]                     len;
   } rc4sc_key_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] ks;
      logic              not_keyed;
   } rc4sc_result_type;

endpackage

`default_nettype wire

// File: rtl/rc4sc_engine.sv
// Sequencer, shared byte adder and 256 x 8 state memory of the RC4 core.
// Runs the key schedule and the keystream generator; uses rc4sc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rc4sc_engine
   import rc4sc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rc4sc_start_type  start,
   input  wire rc4sc_key_type    key,
   input  wire logic             slot_free,
   output      logic             idle,
   output      rc4sc_result_type result
);

   logic [BYTE_W-1:0] perm_mem [TABLE_SIZE];
   logic [BYTE_W-1:0] rd_data_ff;

   rc4sc_state_type state_ff, state_in;
   logic [ADDR_W-1:0] n_ff, n_in;
   logic [KIDX_W-1:0] kidx_ff, kidx_in;
   logic [BYTE_W-1:0] i_ff, i_in;
   logic [BYTE_W-1:0] j_ff, j_in;
   logic [BYTE_W-1:0] si_ff, si_in;
   logic [BYTE_W-1:0] sj_ff, sj_in;
   logic              keyed_ff, keyed_in;
   logic              nk_ff, nk_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] add_a, add_b, add_c, sum;
   logic              last_n;
   logic              kidx_wrap;

   assign sum       = add_a + add_b + add_c;
   assign last_n    = (n_ff == LAST_ADDR);
   assign kidx_wrap = ((LEN_W'(kidx_ff) + LEN_W'(1)) == key.len);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start.valid) begin
               if (start.is_data == REQ_REKEY) begin
                  state_in = ST_FILL;
               end else if (keyed_ff) begin
                  state_in = ST_GEN_RD_I;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_FILL: begin
            if (last_n) begin
               state_in = ST_KS_RD_I;
            end
         end
         ST_KS_RD_I:  state_in = ST_KS_RD_J;
         ST_KS_RD_J:  state_in = ST_KS_WR_J;
         ST_KS_WR_J:  state_in = ST_KS_WR_I;
         ST_KS_WR_I: begin
            state_in = last_n ? ST_IDLE : ST_KS_RD_I;
         end
         ST_GEN_RD_I: state_in = ST_GEN_RD_J;
         ST_GEN_RD_J: state_in = ST_GEN_WR_J;
         ST_GEN_WR_J: state_in = ST_GEN_WR_I;
         ST_GEN_WR_I: state_in = ST_GEN_RD_K;
         ST_GEN_RD_K: state_in = ST_RESULT;
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = n_ff;
      wr_data = si_ff;
      rd_en   = 1'b0;
      rd_addr = n_ff;
      add_a   = j_ff;
      add_b   = rd_data_ff;
      add_c   = '0;
      case (state_ff)
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_data = n_ff;
         end
         ST_KS_RD_I: begin
            rd_en = 1'b1;
         end
         ST_KS_RD_J: begin
            add_c   = key.bytes[kidx_ff];
            rd_en   = 1'b1;
            rd_addr = sum;
         end
         ST_KS_WR_J: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
         end
         ST_KS_WR_I: begin
            wr_en   = 1'b1;
            wr_data = sj_ff;
         end
         ST_GEN_RD_I: begin
            add_a   = i_ff;
            add_b   = BYTE_W'(1);
            rd_en   = 1'b1;
            rd_addr = sum;
         end
         ST_GEN_RD_J: begin
            rd_en   = 1'b1;
            rd_addr = sum;
         end
         ST_GEN_WR_J: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
         end
         ST_GEN_WR_I: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = sj_ff;
         end
         ST_GEN_RD_K: begin
            add_a   = si_ff;
            add_b   = sj_ff;
            rd_en   = 1'b1;
            rd_addr = sum;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      n_in     = n_ff;
      kidx_in  = kidx_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      si_in    = si_ff;
      sj_in    = sj_ff;
      keyed_in = keyed_ff;
      nk_in    = nk_ff;
      case (state_ff)
         ST_IDLE: begin
            n_in  = '0;
            nk_in = ~keyed_ff;
         end
         ST_FILL: begin
            n_in = n_ff + ADDR_W'(1);
            if (last_n) begin
               kidx_in = '0;
               j_in    = '0;
            end
         end
         ST_KS_RD_J: begin
            j_in  = sum;
            si_in = rd_data_ff;
         end
         ST_KS_WR_J: begin
            sj_in = rd_data_ff;
         end
         ST_KS_WR_I: begin
            n_in    = n_ff + ADDR_W'(1);
            kidx_in = kidx_wrap ? '0 : kidx_ff + KIDX_W'(1);
            if (last_n) begin
               i_in     = '0;
               j_in     = '0;
               keyed_in = 1'b1;
            end
         end
         ST_GEN_RD_I: begin
            i_in = sum;
         end
         ST_GEN_RD_J: begin
            j_in  = sum;
            si_in = rd_data_ff;
         end
         ST_GEN_WR_J: begin
            sj_in = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         keyed_ff <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         keyed_ff <= keyed_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
      n_ff    <= n_in;
      kidx_ff <= kidx_in;
      si_ff   <= si_in;
      sj_ff   <= sj_in;
      nk_ff   <= nk_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= perm_mem[rd_addr];
      end
   end

   assign idle             = (state_ff == ST_IDLE);
   assign result.valid     = (state_ff == ST_RESULT);
   assign result.ks        = rd_data_ff;
   assign result.not_keyed = nk_ff;

   a_keyed_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(keyed_ff))
      else $error("keyed flag dropped without reset");

   a_nk_matches_keyed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && nk_ff) |-> !keyed_ff)
      else $error("not-keyed result while keyed");

   a_i_moves_in_place: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_GEN_RD_I && state_ff != ST_KS_WR_I) |=> $stable(i_ff))
      else $error("index i changed outside its update steps");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && !slot_free) |=> (state_ff == ST_RESULT))
      else $error("result left before the output slot was free");

endmodule

`default_nettype wire

// File: rtl/rc4_stream_cipher_core.sv
// Top level of the RC4 stream cipher core: key registers, request and
// response handshakes and the output register. Uses rc4sc_pkg and rc4sc_engine.
//
//   Port group   Direction  Contents
//   req_*        in         req_type (0 rekey, 1 data), req_data_byte
//   rsp_*        out        rsp_out_byte, rsp_not_keyed (data items only)
//   csr_*        in         write enable, register index, 64-bit write data
//
// A data item runs from acceptance to the next acceptance through the accept
// step, five accesses to the state memory and the result step. A data item
// before any rekey goes from the accept step straight to the result step. A
// rekey item runs the accept step, an identity fill of all 256 entries, then
// a read i, read j, write j and write i step for each of 256 swap steps.
// Reset is synchronous and clears the indexes and the keyed flag; the key
// registers return to zero and the key length to sixteen. A stalled response
// holds the engine only when its next result is ready; a new item is taken
// while a response waits.
`timescale 1ns / 1ps
`default_nettype none

module rc4_stream_cipher_core
   import rc4sc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic                  req_type,
   input  wire logic [BYTE_W-1:0]     req_data_byte,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [BYTE_W-1:0]     rsp_out_byte,
   output      logic                  rsp_not_keyed,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CSR_DATA_W-1:0] key_low_ff;
   logic [CSR_DATA_W-1:0] key_high_ff;
   logic [LEN_W-1:0]      key_len_ff;
   logic [BYTE_W-1:0]     data_ff;
   logic                  rsp_valid_ff;
   logic [BYTE_W-1:0]     rsp_byte_ff;
   logic                  rsp_nk_ff;

   logic                  engine_idle;
   logic                  slot_free;
   logic                  accept;
   rc4sc_start_type       start;
   rc4sc_key_type         key;
   rc4sc_result_type      result;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         key_len_ff  <= KEY_LEN_MAX;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_KEY_LEN:  key_len_ff  <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      key.bytes = {key_high_ff, key_low_ff};
      if (key_len_ff < KEY_LEN_MIN) begin
         key.len = KEY_LEN_MIN;
      end else if (key_len_ff > KEY_LEN_MAX) begin
         key.len = KEY_LEN_MAX;
      end else begin
         key.len = key_len_ff;
      end
   end

   assign req_ready     = engine_idle;
   assign accept        = req_valid && req_ready;
   assign start.valid   = accept;
   assign start.is_data = req_type;
   assign slot_free     = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data_byte;
      end
   end

   rc4sc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .key       (key),
      .slot_free (slot_free),
      .idle      (engine_idle),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (result.valid && slot_free) begin
         rsp_byte_ff <= result.not_keyed ? '0 : (data_ff ^ result.ks);
         rsp_nk_ff   <= result.not_keyed;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_not_keyed = rsp_nk_ff;

endmodule

`default_nettype wire
